### sv/rtp_packet_framer_defines.svh
// Assertion macros shared by the RTP framer RTL.
// Needs a clk and an active-low rst_n in the scope where they are used.
`ifndef RTP_PACKET_FRAMER_DEFINES_SVH
`define RTP_PACKET_FRAMER_DEFINES_SVH

// Checked only while out of reset.
`define RTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rtp_pkg.sv
// Package for the RTP packet framer: constants, codes and shared types.
// No dependencies.
`default_nettype none

package rtp_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1500;
  localparam int RTP_HDR_BYTES        = 12;
  localparam int CMD_QUEUE_DEPTH      = 4;

  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [6:0] PT_RESET         = 7'd96;

  // Configuration register indexes
  localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
  localparam logic [1:0] REG_SYNC_SOURCE  = 2'd1;
  localparam logic [1:0] REG_TCP_FRAMING  = 2'd2;
  localparam logic [1:0] REG_START_SEQ    = 2'd3;

  // Result status codes
  localparam logic ST_BYTE    = 1'b0;
  localparam logic ST_DROPPED = 1'b1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_DROP  = 2'd2
  } cmd_kind_t;

  // Byte position within a framed packet start
  typedef enum logic [3:0] {
    PH_LEN_HI  = 4'd0,
    PH_LEN_LO  = 4'd1,
    PH_VER     = 4'd2,
    PH_PT      = 4'd3,
    PH_SEQ_HI  = 4'd4,
    PH_SEQ_LO  = 4'd5,
    PH_TS3     = 4'd6,
    PH_TS2     = 4'd7,
    PH_TS1     = 4'd8,
    PH_TS0     = 4'd9,
    PH_SSRC3   = 4'd10,
    PH_SSRC2   = 4'd11,
    PH_SSRC1   = 4'd12,
    PH_SSRC0   = 4'd13,
    PH_DATA    = 4'd14
  } phase_t;

  // One classified request handed from front to back
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic        last;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] timestamp;
    logic [15:0] total_len;
  } cmd_t;

  // Framing settings seen by the back end
  typedef struct packed {
    logic [6:0]  ptype;
    logic [31:0] sync_source;
    logic        tcp_framing;
  } frame_cfg_t;

endpackage

`default_nettype wire

### sv/rtp_in_if.sv
// Input channel of the RTP framer: payload bytes with packet fields.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface rtp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic        first_byte;
  logic        last_byte;
  logic [31:0] media_timestamp;
  logic        marker_bit;
  logic [15:0] payload_length;

  modport source (output valid, payload_byte, first_byte, last_byte,
                  media_timestamp, marker_bit, payload_length, input ready);
  modport sink   (input valid, payload_byte, first_byte, last_byte,
                  media_timestamp, marker_bit, payload_length, output ready);
endinterface

`default_nettype wire

### sv/rtp_out_if.sv
// Result channel of the RTP framer: framed bytes with end and status flags.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface rtp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_packet;
  logic       status;

  modport source (output valid, out_byte, end_of_packet, status, input ready);
  modport sink   (input valid, out_byte, end_of_packet, status, output ready);
endinterface

`default_nettype wire

### sv/rtp_front.sv
// Front end: accepts payload bytes, tracks packet state, issues requests.
// Uses rtp_pkg and rtp_in_if.
`default_nettype none

module rtp_front
  import rtp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rtp_in_if.sink     in_ch,
  input  wire logic  seq_load,
  input  wire logic [15:0] seq_value,
  input  wire logic  queue_full,
  output logic       push,
  output cmd_t       push_cmd
);

  localparam logic [15:0] MAX_PAYLOAD = 16'(MAX_PACKET_BYTES - RTP_HDR_BYTES);

  logic [15:0] next_seq_r, next_seq_nxt;
  logic        in_packet_r, in_packet_nxt;
  logic        dropping_r, dropping_nxt;
  logic        accept;

  assign in_ch.ready = !queue_full;
  assign accept      = in_ch.valid && !queue_full;

  // Classify the accepted byte
  always_comb begin
    next_seq_nxt  = next_seq_r;
    in_packet_nxt = in_packet_r;
    dropping_nxt  = dropping_r;
    push          = 1'b0;
    push_cmd.kind      = CMD_BYTE;
    push_cmd.data      = in_ch.payload_byte;
    push_cmd.last      = in_ch.last_byte;
    push_cmd.marker    = in_ch.marker_bit;
    push_cmd.seq       = next_seq_r;
    push_cmd.timestamp = in_ch.media_timestamp;
    push_cmd.total_len = in_ch.payload_length + 16'(RTP_HDR_BYTES);
    if (accept) begin
      if (in_ch.first_byte) begin
        push = 1'b1;
        if (in_ch.payload_length > MAX_PAYLOAD) begin
          push_cmd.kind = CMD_DROP;
          in_packet_nxt = 1'b0;
          dropping_nxt  = !in_ch.last_byte;
        end else begin
          push_cmd.kind = CMD_START;
          next_seq_nxt  = next_seq_r + 16'd1;
          in_packet_nxt = !in_ch.last_byte;
          dropping_nxt  = 1'b0;
        end
      end else if (dropping_r) begin
        // swallow the rest of a dropped packet
        if (in_ch.last_byte) dropping_nxt = 1'b0;
      end else if (in_packet_r) begin
        push = 1'b1;
        if (in_ch.last_byte) in_packet_nxt = 1'b0;
      end
    end
    // a start_seq write loads the counter
    if (seq_load) next_seq_nxt = seq_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r  <= '0;
      in_packet_r <= 1'b0;
      dropping_r  <= 1'b0;
    end else begin
      next_seq_r  <= next_seq_nxt;
      in_packet_r <= in_packet_nxt;
      dropping_r  <= dropping_nxt;
    end
  end

endmodule

`default_nettype wire

### sv/rtp_cmd_fifo.sv
// Short request queue between the front and back ends.
// Uses rtp_pkg and the assertion macros header.
`default_nettype none
`include "rtp_packet_framer_defines.svh"

module rtp_cmd_fifo
  import rtp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  localparam int DEPTH = CMD_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      if (do_push && !do_pop)      count_r <= count_r + CW'(1);
      else if (do_pop && !do_push) count_r <= count_r - CW'(1);
    end
  end

  `RTP_ASSERT(a_no_push_full, push |-> !full, "request pushed into a full queue")
  `RTP_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

### sv/rtp_back.sv
// Back end: expands requests into prefix, header and payload bytes and drop results.
// Uses rtp_pkg, rtp_out_if and the assertion macros header.
`default_nettype none
`include "rtp_packet_framer_defines.svh"

module rtp_back
  import rtp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  frame_cfg_t cfg,
  input  cmd_t      head,
  input  wire logic empty,
  output logic      pop,
  rtp_out_if.source out_ch
);

  logic       busy_r, busy_nxt;
  phase_t     phase_r, phase_nxt;
  phase_t     eff_phase;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_eop_r, out_eop_nxt;
  logic       out_status_r, out_status_nxt;
  logic       load;

  assign load      = !out_valid_r || out_ch.ready;
  assign eff_phase = busy_r ? phase_r : (cfg.tcp_framing ? PH_LEN_HI : PH_VER);

  // Byte sequencer
  always_comb begin
    busy_nxt       = busy_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_eop_nxt    = out_eop_r;
    out_status_nxt = out_status_r;
    pop            = 1'b0;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        out_eop_nxt    = 1'b0;
        out_status_nxt = ST_BYTE;
        case (head.kind)
          CMD_START: begin
            case (eff_phase)
              PH_LEN_HI: out_byte_nxt = head.total_len[15:8];
              PH_LEN_LO: out_byte_nxt = head.total_len[7:0];
              PH_VER:    out_byte_nxt = RTP_VERSION_BYTE;
              PH_PT:     out_byte_nxt = {head.marker, cfg.ptype};
              PH_SEQ_HI: out_byte_nxt = head.seq[15:8];
              PH_SEQ_LO: out_byte_nxt = head.seq[7:0];
              PH_TS3:    out_byte_nxt = head.timestamp[31:24];
              PH_TS2:    out_byte_nxt = head.timestamp[23:16];
              PH_TS1:    out_byte_nxt = head.timestamp[15:8];
              PH_TS0:    out_byte_nxt = head.timestamp[7:0];
              PH_SSRC3:  out_byte_nxt = cfg.sync_source[31:24];
              PH_SSRC2:  out_byte_nxt = cfg.sync_source[23:16];
              PH_SSRC1:  out_byte_nxt = cfg.sync_source[15:8];
              PH_SSRC0:  out_byte_nxt = cfg.sync_source[7:0];
              PH_DATA: begin
                out_byte_nxt = head.data;
                out_eop_nxt  = head.last;
              end
              default:   out_byte_nxt = head.data;
            endcase
            if (eff_phase == PH_DATA) begin
              pop      = 1'b1;
              busy_nxt = 1'b0;
            end else begin
              busy_nxt  = 1'b1;
              phase_nxt = phase_t'(eff_phase + 4'd1);
            end
          end
          CMD_DROP: begin
            out_byte_nxt   = 8'h00;
            out_eop_nxt    = 1'b1;
            out_status_nxt = ST_DROPPED;
            pop            = 1'b1;
            busy_nxt       = 1'b0;
          end
          default: begin
            out_byte_nxt = head.data;
            out_eop_nxt  = head.last;
            pop          = 1'b1;
            busy_nxt     = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_LEN_HI;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload, no reset needed
  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_eop_r    <= out_eop_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_byte      = out_byte_r;
  assign out_ch.end_of_packet = out_eop_r;
  assign out_ch.status        = out_status_r;

  `RTP_ASSERT(a_busy_has_cmd, busy_r |-> !empty, "header in progress with empty queue")
  `RTP_ASSERT(a_drop_ends, (out_valid_r && out_status_r) |-> out_eop_r,
              "drop result without end of packet")

endmodule

`default_nettype wire

### sv/rtp_packet_framer.sv
// Top level of the RTP packet framer: configuration registers and the
// front end, request queue and back end. Uses rtp_pkg and the channel interfaces.
//
//   channel  | dir | handshake     | payload
//   in_ch    | in  | valid/ready   | payload_byte, first/last_byte, timestamp, marker, length
//   out_ch   | out | valid/ready   | out_byte, end_of_packet, status
//   cfg_*    | in  | write enable  | cfg_index (2 bits), cfg_data (32 bits)
//
// Payload bytes pass from in_ch to out_ch at one per cycle while out_ch is ready and
// no header is being emitted. A packet start occupies the back-end sequencer while it
// emits the length prefix (TCP framing only), the RTP header and the first payload
// byte; the 4-entry request queue keeps taking input meanwhile and the input stalls
// once it fills. A drop request yields one end-of-packet result. Reset is synchronous.
// A stalled out_ch holds the output register; the front keeps filling the queue.
`default_nettype none

module rtp_packet_framer
  import rtp_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  rtp_in_if.sink           in_ch,
  rtp_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  frame_cfg_t cfg_r;
  cmd_t       push_cmd, head;
  logic       push, pop, empty, full;
  logic       seq_load;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ptype        <= PT_RESET;
      cfg_r.sync_source  <= '0;
      cfg_r.tcp_framing  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAYLOAD_TYPE: cfg_r.ptype        <= cfg_data[6:0];
        REG_SYNC_SOURCE:  cfg_r.sync_source  <= cfg_data;
        REG_TCP_FRAMING:  cfg_r.tcp_framing  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign seq_load = cfg_we && (cfg_index == REG_START_SEQ);

  rtp_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .seq_load  (seq_load),
    .seq_value (cfg_data[15:0]),
    .queue_full(full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rtp_cmd_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .empty   (empty),
    .full    (full)
  );

  rtp_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule

`default_nettype wire
